### sv/pbma_pkg.sv
// ----------------------------------------------------------------------------
// pbma_pkg: shared types and constants
// Widths, function codes, controller states and the command/status bundles
// exchanged between the controller and the datapath of the per-bin mean unit.
// ----------------------------------------------------------------------------
package pbma_pkg;

    // store geometry
    localparam int NUM_BINS  = 256;
    localparam int SUM_WIDTH = 48;
    localparam int BIN_IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CODE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 32;
    localparam int MEAN_W  = 32;
    localparam int CFG_W   = 9;

    // divider step counter
    localparam int DIV_CNT_W = $clog2(SUM_WIDTH);

    // bin count as a limit in the config width
    localparam logic [CFG_W-1:0] BIN_LIMIT = CFG_W'(NUM_BINS);
    localparam logic [CFG_W-1:0] ACTIVE_BINS_RST = 9'd256;

    // function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACC   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic clear;
        logic acc_write;
        logic read_start;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              acc_ok;
        logic              rd_zero;
        logic              div_busy;
        logic              out_free;
    } dp_status_t;

endpackage

### sv/pbma_div.sv
// ----------------------------------------------------------------------------
// pbma_div: restoring divider
// Unsigned SUM_WIDTH-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbma_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pbma_pkg::SUM_WIDTH-1:0] dividend,
    input  logic [pbma_pkg::COUNT_W-1:0]   divisor,
    output logic                           busy,
    output logic [pbma_pkg::SUM_WIDTH-1:0] quotient
);
    import pbma_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [SUM_WIDTH-1:0] quo_reg;
    logic [COUNT_W-1:0]   dvs_reg;

    logic [COUNT_W:0]     shifted;
    logic [COUNT_W+1:0]   trial;
    logic                 fits;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~trial[COUNT_W+1];

    // control: busy flag and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == DIV_CNT_W'(SUM_WIDTH - 1)) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            quo_reg <= {quo_reg[SUM_WIDTH-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### sv/pbma_datapath.sv
// ----------------------------------------------------------------------------
// pbma_datapath: bin store, accumulate adder, mean divider and output register
// Sums and counts live in a registered-read memory; per-bin valid bits give
// the zero reset and a clear of all bins at once.
// ----------------------------------------------------------------------------
module pbma_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pbma_pkg::ctrl_cmd_t           cmd,
    output pbma_pkg::dp_status_t          status,
    input  logic [pbma_pkg::FUNC_W-1:0]   s_func,
    input  logic [pbma_pkg::CODE_W-1:0]   s_bin_code,
    input  logic signed [pbma_pkg::VALUE_W-1:0] s_sample_value,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pbma_pkg::CFG_W-1:0]    cfg_active_bins,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pbma_pkg::CODE_W-1:0]   m_read_bin,
    output logic signed [pbma_pkg::MEAN_W-1:0] m_bin_mean,
    output logic [pbma_pkg::COUNT_W-1:0]  m_bin_count
);
    import pbma_pkg::*;

    localparam int EXT_W = SUM_WIDTH - VALUE_W + 1;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic [MEAN_W-1:0]    MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0]    MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    // configuration register
    logic [CFG_W-1:0] active_bins_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_bins_reg <= ACTIVE_BINS_RST;
        end else if (cfg_valid && cfg_ready) begin
            active_bins_reg <= cfg_active_bins;
        end
    end

    // latched input word
    logic [FUNC_W-1:0]  func_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [VALUE_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= s_func;
            code_reg  <= s_bin_code;
            value_reg <= s_sample_value;
        end
    end

    // bin store with registered read
    logic [SUM_WIDTH-1:0] sum_mem [NUM_BINS];
    logic [COUNT_W-1:0]   cnt_mem [NUM_BINS];
    logic [NUM_BINS-1:0]  valid_reg;
    logic [SUM_WIDTH-1:0] rd_sum_reg;
    logic [COUNT_W-1:0]   rd_cnt_reg;
    logic                 rd_valid_reg;
    logic [BIN_IDX_W-1:0] addr;
    logic [SUM_WIDTH-1:0] new_sum;
    logic [COUNT_W-1:0]   new_cnt;

    assign addr = code_reg[BIN_IDX_W-1:0];

    always_ff @(posedge aclk) begin
        rd_sum_reg <= sum_mem[addr];
        rd_cnt_reg <= cnt_mem[addr];
        if (cmd.acc_write) begin
            sum_mem[addr] <= new_sum;
            cnt_mem[addr] <= new_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[addr];
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.acc_write) begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    // entry as seen through its valid bit
    logic [SUM_WIDTH-1:0] eff_sum;
    logic [COUNT_W-1:0]   eff_cnt;
    logic                 in_store;
    logic                 in_active;

    assign eff_sum   = rd_valid_reg ? rd_sum_reg : '0;
    assign eff_cnt   = rd_valid_reg ? rd_cnt_reg : '0;
    assign in_store  = ({1'b0, code_reg} < BIN_LIMIT);
    assign in_active = ({1'b0, code_reg} < active_bins_reg) && in_store;

    // saturating accumulate
    logic [SUM_WIDTH:0] sum_ext;

    assign sum_ext = {eff_sum[SUM_WIDTH-1], eff_sum}
                   + {{EXT_W{value_reg[VALUE_W-1]}}, value_reg};

    always_comb begin
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            new_sum = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            new_sum = sum_ext[SUM_WIDTH-1:0];
        end
    end

    assign new_cnt = eff_cnt + 1'b1;

    // read setup: magnitude plus half count, one adder with carry-in
    logic [COUNT_W-1:0]   rd_count;
    logic                 sum_neg;
    logic [SUM_WIDTH-1:0] dividend;
    logic                 neg_reg;
    logic                 zero_reg;
    logic [COUNT_W-1:0]   count_out_reg;

    assign rd_count = in_store ? eff_cnt : '0;
    assign sum_neg  = eff_sum[SUM_WIDTH-1];
    assign dividend = (eff_sum ^ {SUM_WIDTH{sum_neg}})
                    + SUM_WIDTH'(eff_cnt >> 1)
                    + SUM_WIDTH'(sum_neg);

    always_ff @(posedge aclk) begin
        if (cmd.read_start) begin
            neg_reg       <= sum_neg;
            zero_reg      <= (rd_count == '0);
            count_out_reg <= rd_count;
        end
    end

    // mean divider
    logic                 div_busy;
    logic [SUM_WIDTH-1:0] quotient;

    pbma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.read_start),
        .dividend (dividend),
        .divisor  (eff_cnt),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // clamp to the 32-bit signed range
    logic [MEAN_W-1:0] mean_val;
    logic              q_above_pos;
    logic              q_above_neg;

    assign q_above_pos = |quotient[SUM_WIDTH-1:MEAN_W-1];
    assign q_above_neg = (|quotient[SUM_WIDTH-1:MEAN_W])
                       || (quotient[MEAN_W-1] && (|quotient[MEAN_W-2:0]));

    always_comb begin
        if (zero_reg) begin
            mean_val = '0;
        end else if (neg_reg) begin
            mean_val = q_above_neg ? MEAN_MIN : (MEAN_W'(0) - quotient[MEAN_W-1:0]);
        end else begin
            mean_val = q_above_pos ? MEAN_MAX : quotient[MEAN_W-1:0];
        end
    end

    // output register
    logic                 m_valid_reg;
    logic [CODE_W-1:0]    read_bin_reg;
    logic [MEAN_W-1:0]    mean_reg;
    logic [COUNT_W-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            read_bin_reg <= code_reg;
            mean_reg     <= mean_val;
            count_reg    <= count_out_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_bin  = read_bin_reg;
    assign m_bin_mean  = mean_reg;
    assign m_bin_count = count_reg;

    // status back to the controller
    always_comb begin
        status.func     = func_reg;
        status.acc_ok   = in_active && (eff_cnt != '1);
        status.rd_zero  = (rd_count == '0);
        status.div_busy = div_busy;
        status.out_free = ~m_valid_reg || m_ready;
    end

endmodule

### sv/pbma_ctrl.sv
// ----------------------------------------------------------------------------
// pbma_ctrl: item sequencer
// Accepts one word, waits for the store read, then accumulates, clears or
// reads a bin (divide if filled), handing the result to the output register.
// ----------------------------------------------------------------------------
module pbma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pbma_pkg::dp_status_t status,
    output pbma_pkg::ctrl_cmd_t  cmd
);
    import pbma_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH: begin
                case (status.func)
                    FUNC_ACC, FUNC_READ: begin
                        state_next = ST_EXEC;
                    end
                    FUNC_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EXEC: begin
                if (status.func == FUNC_ACC) begin
                    cmd.acc_write = status.acc_ok;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.read_start = 1'b1;
                    state_next     = status.rd_zero ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/per_bin_mean_accumulator_unit.sv
// Operation: each word is latched and its bin read from the store; an accumulate writes the
// bin back if it is active and its count is not full, a clear drops all valid bits, and a
// read runs the bit-serial divider (not for an empty bin) before loading the output register.
// Throughput: one word at a time, after the last one is through, including any output wait.
// Reset: synchronous active-low aresetn empties every bin at once through per-bin valid bits
// and sets active_bins to 256; no clearing pass is needed.
// ----------------------------------------------------------------------------
// per_bin_mean_accumulator_unit: per-bin mean table
// Accumulates signed Q16.16 values into bins by code and returns the rounded
// mean and count of a bin on a read word.
// ----------------------------------------------------------------------------
module per_bin_mean_accumulator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pbma_pkg::FUNC_W-1:0]         s_func,
    input  logic [pbma_pkg::CODE_W-1:0]         s_bin_code,
    input  logic signed [pbma_pkg::VALUE_W-1:0] s_sample_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pbma_pkg::CODE_W-1:0]         m_read_bin,
    output logic signed [pbma_pkg::MEAN_W-1:0]  m_bin_mean,
    output logic [pbma_pkg::COUNT_W-1:0]        m_bin_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbma_pkg::CFG_W-1:0]          cfg_active_bins
);
    import pbma_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    pbma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // store and arithmetic
    pbma_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_func          (s_func),
        .s_bin_code      (s_bin_code),
        .s_sample_value  (s_sample_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_active_bins (cfg_active_bins),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_bin      (m_read_bin),
        .m_bin_mean      (m_bin_mean),
        .m_bin_count     (m_bin_count)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for per_bin_mean_accumulator_unit
// Drives accumulate, read, clear and unused-code words with random idle gaps
// and output stalls. Every read result is checked field by field against the
// typed expectation of a directed row or an in-bench model of the bin sums,
// counts and active_bins limit. Covers reset state, value extremes, rounding
// ties and several active_bins settings from 0 to 511.
// ----------------------------------------------------------------------------
module tb;
    import pbma_pkg::*;

    // function code the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // cycles to let an accumulate or clear settle before a register write
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_WORDS = 250;

    typedef struct packed {
        logic [CODE_W-1:0]  bin;
        logic [MEAN_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
    } bin_report_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [MEAN_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
    } stim_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [FUNC_W-1:0]          s_func;
    logic [CODE_W-1:0]          s_bin_code;
    logic signed [VALUE_W-1:0]  s_sample_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [CODE_W-1:0]          m_read_bin;
    logic signed [MEAN_W-1:0]   m_bin_mean;
    logic [COUNT_W-1:0]         m_bin_count;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           cfg_active_bins;

    // model of the bin store
    longint             sum_table [NUM_BINS];
    logic [COUNT_W-1:0] count_table [NUM_BINS];
    int                 active_bins_now;

    bin_report_t pending_reports[$];
    stim_row_t   directed_rows[$];

    int mismatch_count;
    int words_sent;
    int reports_checked;
    int settings_used;
    bit tx_steady;
    bit rx_steady;
    int rx_hold;

    per_bin_mean_accumulator_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_bin_code      (s_bin_code),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_bin      (m_read_bin),
        .m_bin_mean      (m_bin_mean),
        .m_bin_count     (m_bin_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_active_bins (cfg_active_bins)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog
    initial begin : watchdog
        #(60_000_000);
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] error: %s", $time, msg);
        mismatch_count++;
    endtask

    // bins that accept accumulates under the current setting
    function automatic int eff_limit();
        return (active_bins_now < NUM_BINS) ? active_bins_now : NUM_BINS;
    endfunction

    // add with clamp to the signed sum width
    function automatic longint sat_sum(input longint s, input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > 0 && s > hi - v)
            return hi;
        if (v < 0 && s < lo - v)
            return lo;
        return s + v;
    endfunction

    // sum / count, nearest with ties away from zero, clamped to 32 bits
    function automatic logic [MEAN_W-1:0] rounded_mean(input longint s,
                                                       input logic [COUNT_W-1:0] c);
        longint unsigned mag;
        longint unsigned q;
        if (c == 0)
            return '0;
        mag = (s < 0) ? -s : s;
        q = (mag + longint'(c >> 1)) / longint'(c);
        if (s < 0) begin
            if (q > 64'd2147483648)
                q = 64'd2147483648;
            return 32'(-longint'(q));
        end
        if (q > 64'd2147483647)
            q = 64'd2147483647;
        return 32'(q);
    endfunction

    // update the bin model for one word; returns 1 when a read result is due
    function automatic bit apply_word(input logic [FUNC_W-1:0] func,
                                      input logic [CODE_W-1:0] code,
                                      input logic signed [VALUE_W-1:0] value,
                                      output bin_report_t rep);
        longint v;
        v = value;
        rep = '0;
        case (func)
            FUNC_ACC: begin
                if (code < eff_limit() && count_table[code] != '1) begin
                    sum_table[code] = sat_sum(sum_table[code], v);
                    count_table[code] = count_table[code] + 1;
                end
                return 1'b0;
            end
            FUNC_READ: begin
                rep.bin = code;
                rep.count = count_table[code];
                rep.mean = rounded_mean(sum_table[code], count_table[code]);
                return 1'b1;
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < NUM_BINS; i++) begin
                    sum_table[i] = 0;
                    count_table[i] = '0;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // idle length: mostly none, sometimes short, rarely long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CODE_W-1:0] draw_code();
        int lim;
        lim = eff_limit();
        if (lim > 0 && $urandom_range(0, 99) < 85) begin
            if (lim > 16 && $urandom_range(0, 1) == 1)
                return 8'($urandom_range(0, 15));
            return 8'($urandom_range(0, lim - 1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 2000)) - 32'd1000;
            3: return {16'($urandom_range(0, 7)) - 16'd4, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // present one word, wait for its handshake, then predict
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [CODE_W-1:0] code,
                             input logic [VALUE_W-1:0] value, input bit typed,
                             input logic [MEAN_W-1:0] t_mean, input logic [COUNT_W-1:0] t_count);
        int gap;
        bin_report_t rep;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_func = func;
        s_bin_code = code;
        s_sample_value = value;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (apply_word(func, code, value, rep)) begin
            if (typed) begin
                rep.mean = t_mean;
                rep.count = t_count;
            end
            pending_reports.push_back(rep);
        end
    endtask

    // write active_bins once the block has gone quiet
    task automatic write_active_bins(input logic [CFG_W-1:0] value);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_active_bins = value;
        do @(posedge aclk); while (!cfg_ready);
        active_bins_now = value;
        settings_used++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(input logic [FUNC_W-1:0] func, input logic [CODE_W-1:0] code,
                           input logic [VALUE_W-1:0] value, input logic typed,
                           input logic [MEAN_W-1:0] mean, input logic [COUNT_W-1:0] count);
        stim_row_t row;
        row.func = func;
        row.code = code;
        row.value = value;
        row.typed = typed;
        row.mean = mean;
        row.count = count;
        directed_rows.push_back(row);
    endtask

    // result side: random stalls with steady stretches
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready = 1'b0;
            rx_hold--;
        end else begin
            m_ready = 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 20)
                rx_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                       : $urandom_range(8, 40);
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_reports
        bin_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch($sformatf("result for bin %0d with none expected", m_read_bin));
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (m_read_bin !== want.bin)
                    flag_mismatch($sformatf("read_bin %0d, expected %0d",
                                            m_read_bin, want.bin));
                if (m_bin_mean !== want.mean)
                    flag_mismatch($sformatf("bin %0d mean %h, expected %h",
                                            want.bin, m_bin_mean, want.mean));
                if (m_bin_count !== want.count)
                    flag_mismatch($sformatf("bin %0d count %0d, expected %0d",
                                            want.bin, m_bin_count, want.count));
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0]   cfg_plan [8];
        logic [FUNC_W-1:0]  f;
        logic [CODE_W-1:0]  c;
        logic [VALUE_W-1:0] v;
        int                 r;
        int                 done_items;

        s_valid = 1'b0;
        s_func = FUNC_ACC;
        s_bin_code = '0;
        s_sample_value = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_active_bins = '0;
        aresetn = 1'b0;
        mismatch_count = 0;
        words_sent = 0;
        reports_checked = 0;
        settings_used = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold = 0;
        active_bins_now = ACTIVE_BINS_RST;
        for (int i = 0; i < NUM_BINS; i++) begin
            sum_table[i] = 0;
            count_table[i] = '0;
        end

        // reset
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words; typed rows carry their expected mean and count
        add_row(FUNC_READ,   8'd0,   32'h0,         1'b1, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd255, 32'h0,         1'b1, 32'h0,         32'd0);
        add_row(FUNC_ACC,    8'd0,   32'h7FFF_FFFF, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd0,   32'h0,         1'b1, 32'h7FFF_FFFF, 32'd1);
        add_row(FUNC_ACC,    8'd255, 32'h8000_0000, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_ACC,    8'd255, 32'h8000_0000, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd255, 32'h0,         1'b1, 32'h8000_0000, 32'd2);
        // ties round away from zero on both signs
        add_row(FUNC_ACC,    8'd7,   32'd1,         1'b0, 32'h0,         32'd0);
        add_row(FUNC_ACC,    8'd7,   32'd2,         1'b0, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd7,   32'h0,         1'b1, 32'd2,         32'd2);
        add_row(FUNC_ACC,    8'd8,   32'hFFFF_FFFF, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_ACC,    8'd8,   32'hFFFF_FFFE, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd8,   32'h0,         1'b1, 32'hFFFF_FFFE, 32'd2);
        // unused code leaves bin 0 alone
        add_row(FUNC_UNUSED, 8'd0,   32'h1234_5678, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd0,   32'h0,         1'b1, 32'h7FFF_FFFF, 32'd1);
        add_row(FUNC_ACC,    8'd9,   32'h0001_8000, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_ACC,    8'd9,   32'h5555_5555, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_ACC,    8'd9,   32'hFFFF_0000, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd9,   32'h0,         1'b0, 32'h0,         32'd0);
        add_row(FUNC_CLEAR,  8'd0,   32'hFFFF_FFFF, 1'b0, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd0,   32'h0,         1'b1, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd255, 32'h0,         1'b1, 32'h0,         32'd0);
        add_row(FUNC_READ,   8'd7,   32'h0,         1'b0, 32'h0,         32'd0);
        foreach (directed_rows[i])
            send_word(directed_rows[i].func, directed_rows[i].code, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].mean, directed_rows[i].count);

        // random phases over several active_bins settings
        cfg_plan[0] = 9'd1;
        cfg_plan[1] = 9'd0;
        cfg_plan[2] = 9'd511;
        cfg_plan[3] = 9'd2;
        cfg_plan[4] = 9'd256;
        cfg_plan[5] = 9'($urandom_range(3, 255));
        cfg_plan[6] = 9'($urandom_range(257, 510));
        cfg_plan[7] = 9'd255;
        for (int p = 0; p < 8; p++) begin
            write_active_bins(cfg_plan[p]);
            tx_steady = (p == 3);
            rx_steady = (p == 3 || p == 6);
            done_items = 0;
            while (done_items < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 62)
                    f = FUNC_ACC;
                else if (r < 97)
                    f = FUNC_READ;
                else if (r < 98)
                    f = FUNC_CLEAR;
                else
                    f = FUNC_UNUSED;
                c = draw_code();
                v = draw_value();
                done_items++;
                send_word(f, c, v, 1'b0, '0, '0);
            end
        end

        // drain
        @(negedge aclk);
        s_valid = 1'b0;
        rx_steady = 1'b1;
        for (int k = 0; k < 5000 && pending_reports.size() != 0; k++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (pending_reports.size() != 0) begin
            flag_mismatch($sformatf("no result for read of bin %0d",
                                    pending_reports[0].bin));
            void'(pending_reports.pop_front());
        end

        $display("Run covered %0d words and %0d checked read results over %0d active_bins",
                 words_sent, reports_checked, settings_used);
        $display("settings, with value extremes and rounding ties checked up front");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
sv/pbma_pkg.sv
sv/pbma_div.sv
sv/pbma_datapath.sv
sv/pbma_ctrl.sv
sv/per_bin_mean_accumulator_unit.sv
sim/tb.sv
